[hdl/bss_pkg.sv]
// Shared types and constants for the byte sequence substituter.
`timescale 1ns / 1ps

package bss_pkg;

    localparam int TABLE_ENTRIES_DEF     = 256;
    localparam int MAX_PATTERN_BYTES_DEF = 4;
    localparam int WORD_W                = 32;
    localparam int LEN_W                 = 3;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    // one table row: pattern, replacement, lengths
    typedef struct packed {
        logic [WORD_W-1:0] pattern;
        logic [WORD_W-1:0] subst;
        logic [LEN_W-1:0]  rlen;
        logic [LEN_W-1:0]  slen;
    } entry_t;

    // matcher verdict on one row
    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  slen;
        logic [LEN_W-1:0]  rlen;
        logic [WORD_W-1:0] repl;
    } match_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } state_t;

endpackage

[hdl/bss_table.sv]
// Substitution table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bss_table #(
    parameter int DEPTH  = bss_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(bss_pkg::TABLE_ENTRIES_DEF)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  bss_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output bss_pkg::entry_t     rd_data
);

    bss_pkg::entry_t mem [DEPTH];
    bss_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bss_match.sv]
// Compares the window head against one table row.
`timescale 1ns / 1ps

module bss_match #(
    parameter int MAX_BYTES = bss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int CW        = $clog2(bss_pkg::MAX_PATTERN_BYTES_DEF + 1)
) (
    input  logic [MAX_BYTES*8-1:0] window,
    input  logic [CW-1:0]          count,
    input  bss_pkg::entry_t        entry,
    output bss_pkg::match_t        result
);

    localparam int CMP = (MAX_BYTES < 4) ? MAX_BYTES : 4;

    logic eq;

    always_comb
    begin
        eq = 1'b1;
        for (int i = 0; i < CMP; i++)
        begin
            if ((i < int'(entry.slen)) &&
                (window[i*8 +: 8] != entry.pattern[i*8 +: 8]))
            begin
                eq = 1'b0;
            end
        end
        result.hit  = eq && (entry.slen != '0) && (32'(entry.slen) <= 32'(count));
        result.slen = entry.slen;
        result.rlen = entry.rlen;
        result.repl = entry.subst;
    end

endmodule

[hdl/byte_sequence_substituter_core.sv]
// Byte sequence substituter top level: window, search sequencer, output register.
// Load items and data items that neither fill the window nor end the stream
// leave the block idle. A decision walks the table one row per cycle through
// the table memory read port, then emits its bytes as the receiver takes them.
// End of stream repeats decisions until the window is empty. Reset clears the
// window, count, config and control; table contents stay unknown until loaded.
`timescale 1ns / 1ps

module byte_sequence_substituter_core #(
    parameter int TABLE_ENTRIES     = bss_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PATTERN_BYTES = bss_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        entries_in_use_wr,
    input  logic [8:0]  entries_in_use,
    // request in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  entry_index,
    input  logic [31:0] search_pattern,
    input  logic [2:0]  search_length,
    input  logic [31:0] replacement_bytes,
    input  logic [2:0]  replacement_length,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    // request out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        stream_last
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CW    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_W = MAX_PATTERN_BYTES * 8;
    localparam int CAP   = (MAX_PATTERN_BYTES < 4) ? MAX_PATTERN_BYTES : 4;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    bss_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;     // saturated entries_in_use
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                eos_reg, eos_next;         // flushing the window
    logic [CNT_W-1:0]    addr_reg, addr_next;       // next row to read
    logic                rd_pend_reg, rd_pend_next; // row data arrives this cycle

    // decision being emitted
    logic [31:0]         emit_bytes_reg, emit_bytes_next;
    logic [2:0]          emit_len_reg, emit_len_next;
    logic [2:0]          emit_rlen_reg, emit_rlen_next;
    logic [2:0]          emit_idx_reg, emit_idx_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                run_last_reg, run_last_next;
    logic                stream_last_reg, stream_last_next;

    // ------------------------------------------------------------------
    // Table memory and row compare
    // ------------------------------------------------------------------
    logic                tbl_wr_en;
    bss_pkg::entry_t     tbl_wr_data;
    logic                tbl_rd_en;
    bss_pkg::entry_t     tbl_rd_data;
    bss_pkg::match_t     match;
    logic [2:0]          slen_c;
    logic [2:0]          rlen_c;

    bss_table #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDX_W'(entry_index)),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (tbl_rd_data)
    );

    bss_match #(
        .MAX_BYTES (MAX_PATTERN_BYTES),
        .CW        (CW)
    ) u_match (
        .window (window_reg),
        .count  (count_reg),
        .entry  (tbl_rd_data),
        .result (match)
    );

    // lengths clamped on load: search to the pattern cap, replacement to search
    always_comb
    begin
        slen_c = (32'(search_length) > CAP) ? 3'(CAP) : search_length;
        rlen_c = (replacement_length > slen_c) ? slen_c : replacement_length;
        tbl_wr_data.pattern = search_pattern;
        tbl_wr_data.subst   = replacement_bytes;
        tbl_wr_data.slen    = slen_c;
        tbl_wr_data.rlen    = rlen_c;
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic                in_take;
    logic                out_free;
    logic                last_byte;
    logic                final_dec;
    logic [CW-1:0]       count_after;
    logic [WIN_W-1:0]    window_shifted;

    assign in_stall  = (state_reg != bss_pkg::S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign tbl_rd_en = (state_reg == bss_pkg::S_SEARCH) && (addr_reg < limit_reg);

    // emit bookkeeping
    assign last_byte      = (3'(emit_idx_reg + 3'd1) == emit_len_reg);
    assign count_after    = count_reg - CW'(emit_len_reg);
    assign final_dec      = !eos_reg || (count_after == '0);
    assign window_shifted = window_reg >> {emit_len_reg, 3'b000};

    always_comb
    begin
        state_next       = state_reg;
        limit_next       = limit_reg;
        window_next      = window_reg;
        count_next       = count_reg;
        eos_next         = eos_reg;
        addr_next        = addr_reg;
        rd_pend_next     = 1'b0;
        emit_bytes_next  = emit_bytes_reg;
        emit_len_next    = emit_len_reg;
        emit_rlen_next   = emit_rlen_reg;
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        run_last_next    = run_last_reg;
        stream_last_next = stream_last_reg;
        tbl_wr_en        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (entries_in_use_wr)
        begin
            if (32'(entries_in_use) > TABLE_ENTRIES)
            begin
                limit_next = CNT_W'(TABLE_ENTRIES);
            end
            else
            begin
                limit_next = CNT_W'(entries_in_use);
            end
        end

        case (state_reg)
            bss_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    if (action == bss_pkg::ACT_LOAD)
                    begin
                        tbl_wr_en = (32'(entry_index) < TABLE_ENTRIES);
                    end
                    else
                    begin
                        // count is always below the window size here
                        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                        begin
                            if (32'(count_reg) == i)
                            begin
                                window_next[i*8 +: 8] = data_byte;
                            end
                        end
                        count_next = CW'(count_reg + CW'(1));
                        eos_next   = end_of_stream;
                        if (end_of_stream ||
                            (32'(count_reg) + 1 == MAX_PATTERN_BYTES))
                        begin
                            state_next = bss_pkg::S_SEARCH;
                            addr_next  = '0;
                        end
                    end
                end
            end

            bss_pkg::S_SEARCH:
            begin
                if (rd_pend_reg && match.hit)
                begin
                    // first matching row in table order wins
                    emit_bytes_next = match.repl;
                    emit_len_next   = match.slen;
                    emit_rlen_next  = match.rlen;
                    emit_idx_next   = '0;
                    state_next      = bss_pkg::S_EMIT;
                end
                else if (!rd_pend_reg && !tbl_rd_en)
                begin
                    // no row matched: head byte passes through
                    emit_bytes_next = {24'h0, window_reg[7:0]};
                    emit_len_next   = 3'd1;
                    emit_rlen_next  = 3'd1;
                    emit_idx_next   = '0;
                    state_next      = bss_pkg::S_EMIT;
                end
                else
                begin
                    if (tbl_rd_en)
                    begin
                        addr_next = CNT_W'(addr_reg + CNT_W'(1));
                    end
                    rd_pend_next = tbl_rd_en;
                end
            end

            bss_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (emit_idx_reg < emit_rlen_reg)
                    begin
                        out_byte_next = emit_bytes_reg[{emit_idx_reg[1:0], 3'b000} +: 8];
                    end
                    else
                    begin
                        out_byte_next = 8'h00;
                    end
                    run_last_next    = last_byte && final_dec;
                    stream_last_next = last_byte && final_dec && eos_reg;
                    emit_idx_next    = 3'(emit_idx_reg + 3'd1);
                    if (last_byte)
                    begin
                        window_next = window_shifted;
                        count_next  = count_after;
                        if (final_dec)
                        begin
                            eos_next   = 1'b0;
                            state_next = bss_pkg::S_IDLE;
                        end
                        else
                        begin
                            addr_next  = '0;
                            state_next = bss_pkg::S_SEARCH;
                        end
                    end
                end
            end

            default:
            begin
                state_next = bss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bss_pkg::S_IDLE;
            limit_reg     <= '0;
            window_reg    <= '0;
            count_reg     <= '0;
            eos_reg       <= 1'b0;
            addr_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            eos_reg       <= eos_next;
            addr_reg      <= addr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        emit_bytes_reg  <= emit_bytes_next;
        emit_len_reg    <= emit_len_next;
        emit_rlen_reg   <= emit_rlen_next;
        emit_idx_reg    <= emit_idx_next;
        out_byte_reg    <= out_byte_next;
        run_last_reg    <= run_last_next;
        stream_last_reg <= stream_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_last = stream_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_PATTERN_BYTES)
        else $error("window count beyond window size");

    a_emit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bss_pkg::S_EMIT) |->
            ((emit_len_reg != 3'd0) && (32'(emit_len_reg) <= 32'(count_reg))))
        else $error("decision consumes more bytes than the window holds");

    a_stream_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_last_reg) |-> run_last_reg)
        else $error("stream end without run end");

    a_eos_searches: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (action == bss_pkg::ACT_DATA) && end_of_stream) |=>
            (state_reg == bss_pkg::S_SEARCH))
        else $error("end of stream did not start a flush");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for byte_sequence_substituter_core: table-driven stream rewrite.
`timescale 1ns / 1ps

// One request as it crosses the input channel, in port order.
typedef struct packed {
    logic        action;
    logic [7:0]  entry_index;
    logic [31:0] search_pattern;
    logic [2:0]  search_length;
    logic [31:0] replacement_bytes;
    logic [2:0]  replacement_length;
    logic [7:0]  data_byte;
    logic        end_of_stream;
} request_t;

// One output byte with its markers.
typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       stream_last;
} result_t;

class stream_rewrite_checker;
    logic [31:0] pattern_mem [bss_pkg::TABLE_ENTRIES_DEF];
    logic [31:0] subst_mem [bss_pkg::TABLE_ENTRIES_DEF];
    int          slen_mem [bss_pkg::TABLE_ENTRIES_DEF];
    int          rlen_mem [bss_pkg::TABLE_ENTRIES_DEF];
    logic [7:0]  window [bss_pkg::MAX_PATTERN_BYTES_DEF];
    int          window_fill;
    int          entries_active;
    logic [7:0]  run_bytes [$];
    result_t     expected_bytes [$];
    int          failures;

    function new();
        window_fill = 0;
        entries_active = 0;
        failures = 0;
        foreach (window[i])
            window[i] = 8'h00;
    endfunction

    function void set_entries(int n);
        entries_active = (n > bss_pkg::TABLE_ENTRIES_DEF) ? bss_pkg::TABLE_ENTRIES_DEF : n;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // First matching entry at the window head, else one byte passes through.
    function void rewrite_head();
        int  hit_len;
        bit  hit;
        hit_len = 0;
        for (int e = 0; e < entries_active && hit_len == 0; e++)
        begin
            if (slen_mem[e] != 0 && slen_mem[e] <= window_fill)
            begin
                hit = 1'b1;
                for (int i = 0; i < slen_mem[e]; i++)
                    if (window[i] != pattern_mem[e][8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    hit_len = slen_mem[e];
                    for (int i = 0; i < hit_len; i++)
                        run_bytes.push_back(i < rlen_mem[e] ? subst_mem[e][8*i +: 8] : 8'h00);
                end
            end
        end
        if (hit_len == 0)
        begin
            run_bytes.push_back(window[0]);
            hit_len = 1;
        end
        for (int i = 0; i < bss_pkg::MAX_PATTERN_BYTES_DEF; i++)
            window[i] = (i + hit_len < bss_pkg::MAX_PATTERN_BYTES_DEF) ?
                        window[i + hit_len] : 8'h00;
        window_fill -= hit_len;
    endfunction

    function void note_request(request_t r);
        result_t rec;
        int      sl;
        int      rl;
        if (r.action == bss_pkg::ACT_LOAD)
        begin
            sl = r.search_length;
            if (sl > bss_pkg::MAX_PATTERN_BYTES_DEF)
                sl = bss_pkg::MAX_PATTERN_BYTES_DEF;
            rl = r.replacement_length;
            if (rl > sl)
                rl = sl;
            pattern_mem[r.entry_index] = r.search_pattern;
            subst_mem[r.entry_index] = r.replacement_bytes;
            slen_mem[r.entry_index] = sl;
            rlen_mem[r.entry_index] = rl;
            return;
        end
        run_bytes.delete();
        if (window_fill < bss_pkg::MAX_PATTERN_BYTES_DEF)
        begin
            window[window_fill] = r.data_byte;
            window_fill++;
        end
        if (r.end_of_stream)
        begin
            while (window_fill > 0)
                rewrite_head();
        end
        else if (window_fill >= bss_pkg::MAX_PATTERN_BYTES_DEF)
            rewrite_head();
        for (int k = 0; k < run_bytes.size(); k++)
        begin
            rec.value = run_bytes[k];
            rec.run_last = (k == run_bytes.size() - 1);
            rec.stream_last = r.end_of_stream && (k == run_bytes.size() - 1);
            expected_bytes.push_back(rec);
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_bytes.size() == 0)
        begin
            flag($sformatf("unexpected byte %02h run_last %0b stream_last %0b",
                           got.value, got.run_last, got.stream_last));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.value !== want.value || got.run_last !== want.run_last ||
            got.stream_last !== want.stream_last)
            flag($sformatf("byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                           want.value, want.run_last, want.stream_last,
                           got.value, got.run_last, got.stream_last));
    endfunction

    function void check_drained();
        if (expected_bytes.size() != 0)
            flag($sformatf("%0d expected bytes never came out", expected_bytes.size()));
    endfunction
endclass

module tb_top;

    // Longest quiet stretch tolerated: a full 256-row search, plus receiver
    // stalls and the settle pause, taken many times over.
    localparam int STUCK_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        entries_in_use_wr = 1'b0;
    logic [8:0]  entries_in_use = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = bss_pkg::ACT_LOAD;
    logic [7:0]  entry_index = '0;
    logic [31:0] search_pattern = '0;
    logic [2:0]  search_length = '0;
    logic [31:0] replacement_bytes = '0;
    logic [2:0]  replacement_length = '0;
    logic [7:0]  data_byte = '0;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        stream_last;

    // Idle rates in percent; changed per phase by the main sequence.
    int send_idle_pct = 30;
    int recv_stall_pct = 68;

    stream_rewrite_checker rewrite_check = new();

    byte_sequence_substituter_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .entries_in_use_wr  (entries_in_use_wr),
        .entries_in_use     (entries_in_use),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .entry_index        (entry_index),
        .search_pattern     (search_pattern),
        .search_length      (search_length),
        .replacement_bytes  (replacement_bytes),
        .replacement_length (replacement_length),
        .data_byte          (data_byte),
        .end_of_stream      (end_of_stream),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_byte           (out_byte),
        .run_last           (run_last),
        .stream_last        (stream_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Monitor: both channels sampled at the rising edge. Results are checked
    // before the same-edge request is noted; a result never answers a request
    // accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            rewrite_check.check_result({out_byte, run_last, stream_last});
        if (rst_n && in_valid && !in_stall)
            rewrite_check.note_request({action, entry_index, search_pattern, search_length,
                                        replacement_bytes, replacement_length, data_byte,
                                        end_of_stream});
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial
    begin
        int stuck_cycles;
        stuck_cycles = 0;
        wait (rst_n === 1'b1);
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("[byte_sequence_substituter_core] ERROR");
        $finish;
    end

    // Biased toward a few values so patterns overlap and partly match.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) >= 70)
            return 8'($urandom_range(255));
        case ($urandom_range(4))
            0: return 8'h00;
            1: return 8'h41;
            2: return 8'h42;
            3: return 8'h43;
            default: return 8'hFF;
        endcase
    endfunction

    // Table load request; the stream fields carry junk the block must ignore.
    function automatic request_t load_req(int idx, logic [31:0] pat, int slen,
                                          logic [31:0] repl, int rlen);
        request_t r;
        r.action = bss_pkg::ACT_LOAD;
        r.entry_index = idx[7:0];
        r.search_pattern = pat;
        r.search_length = slen[2:0];
        r.replacement_bytes = repl;
        r.replacement_length = rlen[2:0];
        r.data_byte = 8'($urandom_range(255));
        r.end_of_stream = 1'($urandom_range(1));
        return r;
    endfunction

    // Stream byte request; the load fields carry junk.
    function automatic request_t data_req(logic [7:0] b, logic eos);
        request_t r;
        r.action = bss_pkg::ACT_DATA;
        r.entry_index = 8'($urandom_range(255));
        r.search_pattern = $urandom();
        r.search_length = 3'($urandom_range(7));
        r.replacement_bytes = $urandom();
        r.replacement_length = 3'($urandom_range(7));
        r.data_byte = b;
        r.end_of_stream = eos;
        return r;
    endfunction

    // Mostly lengths 1..4, now and then zero or oversize to hit the clamps.
    function automatic request_t random_entry_req(int idx);
        logic [31:0] pat;
        int          sel;
        int          slen;
        int          rlen;
        if ($urandom_range(99) < 15)
            pat = $urandom();
        else
            pat = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        sel = $urandom_range(99);
        if (sel < 5)
            slen = 0;
        else if (sel < 10)
            slen = $urandom_range(7, 5);
        else
            slen = $urandom_range(4, 1);
        rlen = ($urandom_range(99) < 10) ? $urandom_range(7, 5) : $urandom_range(4, 0);
        return load_req(idx, pat, slen, $urandom(), rlen);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests never drop it.
    task automatic send_request(input request_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= r.action;
        entry_index <= r.entry_index;
        search_pattern <= r.search_pattern;
        search_length <= r.search_length;
        replacement_bytes <= r.replacement_bytes;
        replacement_length <= r.replacement_length;
        data_byte <= r.data_byte;
        end_of_stream <= r.end_of_stream;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected byte, then give the block time to
    // finish any request that produces nothing (loads, buffered bytes).
    task automatic settle();
        in_valid <= 1'b0;
        while (rewrite_check.expected_bytes.size() != 0)
            @(negedge clk);
        repeat (rewrite_check.entries_active + 16) @(negedge clk);
    endtask

    task automatic write_entries_in_use(input int n);
        entries_in_use_wr <= 1'b1;
        entries_in_use <= n[8:0];
        @(negedge clk);
        entries_in_use_wr <= 1'b0;
        rewrite_check.set_entries(n);
    endtask

    task automatic fill_table(input int lo, input int hi);
        for (int idx = lo; idx < hi; idx++)
            send_request(random_entry_req(idx));
    endtask

    // Random streams built mostly from table patterns (some with a wrong
    // last byte), with noise bytes and table rewrites mixed in. Each stream
    // closes with an end-of-stream byte. Only entries below n_active are
    // rewritten so no search ever lands on an unloaded row.
    task automatic run_streams(input int n_active, input int budget);
        request_t reqs [$];
        int       sent;
        int       len;
        int       data_cnt;
        int       e;
        int       plen;
        int       sel;
        bit       broken;
        sent = 0;
        while (sent < budget)
        begin
            reqs.delete();
            len = $urandom_range(16, 1);
            data_cnt = 0;
            while (data_cnt < len)
            begin
                sel = $urandom_range(99);
                if (sel < 8)
                    reqs.push_back(random_entry_req($urandom_range(n_active - 1)));
                else if (sel < 65)
                begin
                    e = $urandom_range(n_active - 1);
                    plen = (rewrite_check.slen_mem[e] == 0) ? 1 : rewrite_check.slen_mem[e];
                    broken = ($urandom_range(3) == 0);
                    for (int i = 0; i < plen; i++)
                        reqs.push_back(data_req((broken && i == plen - 1) ? pick_byte()
                                                : rewrite_check.pattern_mem[e][8*i +: 8], 1'b0));
                    data_cnt += plen;
                end
                else
                begin
                    reqs.push_back(data_req(pick_byte(), 1'b0));
                    data_cnt++;
                end
            end
            // the loop always ends on a data byte
            reqs[reqs.size() - 1].end_of_stream = 1'b1;
            foreach (reqs[k])
                send_request(reqs[k]);
            sent += reqs.size();
        end
    endtask

    initial
    begin
        logic [7:0] walk_bytes [16];
        int         n_active;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table in use: every byte passes through, the short stream
        // is flushed by its end-of-stream byte.
        write_entries_in_use(0);
        send_request(data_req(8'h00, 1'b0));
        send_request(data_req(8'hFF, 1'b0));
        send_request(data_req(8'h80, 1'b1));

        // Directed table: zero-length entry that must never match, "AB"
        // ahead of "A" for first-match priority, an oversize pattern length,
        // an all-zero pattern with no replacement (pure zero pad), "XYZ" that
        // cannot match in a two-byte tail, and an oversize replacement.
        send_request(load_req(0, 32'h0000_0000, 0, 32'h1234_5678, 3));
        send_request(load_req(1, 32'h0000_4241, 2, 32'h0000_005A, 1));
        send_request(load_req(2, 32'h0000_0041, 1, 32'h0000_0061, 7));
        send_request(load_req(3, 32'hFFFF_FFFF, 7, 32'hDDCC_BBAA, 4));
        send_request(load_req(4, 32'h0000_0000, 4, 32'hFFFF_FFFF, 0));
        send_request(load_req(5, 32'h005A_5958, 3, 32'h0000_3231, 2));
        send_request(load_req(6, 32'h0000_FF00, 2, 32'h0000_EE11, 5));
        settle();
        write_entries_in_use(7);
        walk_bytes = '{8'h41, 8'h42, 8'h58, 8'h59, 8'h5A, 8'h41, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h58, 8'h59};
        foreach (walk_bytes[i])
            send_request(data_req(walk_bytes[i], i == 15));

        // Small table, slow receiver.
        n_active = $urandom_range(8, 1);
        fill_table(0, n_active);
        settle();
        write_entries_in_use(n_active);
        run_streams(n_active, 60);
        settle();

        // Mid-size table, slow sender.
        send_idle_pct = 68;
        recv_stall_pct = 30;
        n_active = $urandom_range(48, 9);
        fill_table(0, n_active);
        settle();
        write_entries_in_use(n_active);
        run_streams(n_active, 60);
        settle();

        // Same table at full rate on both sides.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_streams(n_active, 60);
        settle();

        rewrite_check.check_drained();
        if (rewrite_check.failures == 0)
            $display("[byte_sequence_substituter_core] OK");
        else
            $display("[byte_sequence_substituter_core] ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/bss_pkg.sv
hdl/bss_table.sv
hdl/bss_match.sv
hdl/byte_sequence_substituter_core.sv
tb/sv/tb_top.sv
